/* src/skt_pkg.sv */
// shared types and codes for the sorted key table
package skt_pkg;

    // operation codes carried from the front to the engine
    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_BEYOND  = 2'd3
    } t_status;

    // encoding of the kind field on the input port
    localparam logic [1:0] KIND_FIND   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

endpackage

/* src/skt_front.sv */
// front end: takes input transfers, decodes the kind and queues commands
module skt_front #(
    parameter int KEY_WIDTH    = 32,
    parameter int HANDLE_WIDTH = 32,
    parameter int POS_WIDTH    = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_kind,
    input  logic [KEY_WIDTH-1:0]    i_key,
    input  logic [HANDLE_WIDTH-1:0] i_handle,
    input  logic [POS_WIDTH-1:0]    i_position,
    output logic                    o_cmd_valid,
    input  logic                    i_cmd_take,
    output skt_pkg::t_op            o_cmd_op,
    output logic [KEY_WIDTH-1:0]    o_cmd_key,
    output logic [HANDLE_WIDTH-1:0] o_cmd_handle,
    output logic [POS_WIDTH-1:0]    o_cmd_pos
);
    import skt_pkg::*;

    localparam int QD = 2;

    t_op                     r_q_op     [QD];
    logic [KEY_WIDTH-1:0]    r_q_key    [QD];
    logic [HANDLE_WIDTH-1:0] r_q_handle [QD];
    logic [POS_WIDTH-1:0]    r_q_pos    [QD];
    logic                    r_wr;
    logic                    r_rd;
    logic [1:0]              r_fill;
    logic                    push;
    logic                    pop;
    t_op                     dec_op;

    always_comb begin
        unique case (i_kind)
            KIND_FIND:   dec_op = OP_FIND;
            KIND_INSERT: dec_op = OP_INSERT;
            KIND_REMOVE: dec_op = OP_REMOVE;
            KIND_READ:   dec_op = OP_READ;
            default:     dec_op = OP_FIND;
        endcase
    end

    assign o_stall     = (r_fill == 2'(QD));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_take;

    assign o_cmd_op     = r_q_op[r_rd];
    assign o_cmd_key    = r_q_key[r_rd];
    assign o_cmd_handle = r_q_handle[r_rd];
    assign o_cmd_pos    = r_q_pos[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_op[r_wr]     <= dec_op;
            r_q_key[r_wr]    <= i_key;
            r_q_handle[r_wr] <= i_handle;
            r_q_pos[r_wr]    <= i_position;
        end
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

/* src/skt_engine.sv */
// back end: table memory, search and shift sequencer, result register
module skt_engine #(
    parameter int CAPACITY     = 1024,
    parameter int KEY_WIDTH    = 32,
    parameter int HANDLE_WIDTH = 32,
    parameter int POS_WIDTH    = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    output logic                    o_cmd_take,
    input  skt_pkg::t_op            i_cmd_op,
    input  logic [KEY_WIDTH-1:0]    i_cmd_key,
    input  logic [HANDLE_WIDTH-1:0] i_cmd_handle,
    input  logic [POS_WIDTH-1:0]    i_cmd_pos,
    output logic                    o_valid,
    input  logic                    i_stall,
    output skt_pkg::t_status        o_status,
    output logic [POS_WIDTH-1:0]    o_where,
    output logic [HANDLE_WIDTH-1:0] o_handle_out,
    output logic [KEY_WIDTH-1:0]    o_key_out,
    output logic [POS_WIDTH-1:0]    o_count
);
    import skt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = POS_WIDTH;
    localparam int DW = KEY_WIDTH + HANDLE_WIDTH;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_PLACE,
        S_READ,
        S_DONE
    } t_state;

    logic [DW-1:0] r_mem [CAPACITY];
    logic [DW-1:0] r_rdata;

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [KEY_WIDTH-1:0]    r_key, n_key;
    logic [HANDLE_WIDTH-1:0] r_handle, n_handle;
    logic [CW-1:0]           r_pos, n_pos;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_base, n_base;
    logic [CW-1:0]           r_span, n_span;
    logic [CW-1:0]           r_idx, n_idx;
    t_status                 r_status, n_status;
    logic [CW-1:0]           r_where, n_where;
    logic [HANDLE_WIDTH-1:0] r_hout, n_hout;
    logic [KEY_WIDTH-1:0]    r_kout, n_kout;
    logic                    r_ovalid, n_ovalid;
    t_status                 r_o_status, n_o_status;
    logic [CW-1:0]           r_o_where, n_o_where;
    logic [HANDLE_WIDTH-1:0] r_o_hout, n_o_hout;
    logic [KEY_WIDTH-1:0]    r_o_kout, n_o_kout;
    logic [CW-1:0]           r_o_count, n_o_count;

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [DW-1:0]           wr_data;

    logic [KEY_WIDTH-1:0]    probe_key;
    logic [HANDLE_WIDTH-1:0] probe_hdl;
    logic [CW-1:0]           mid;
    logic [CW-1:0]           at;
    logic [CW-1:0]           nb;
    logic [CW-1:0]           ns;
    logic [CW-1:0]           next_probe;
    logic [CW-1:0]           cnt_m1;
    logic [CW-1:0]           idx_up;
    logic [CW-1:0]           idx_dn;
    logic [CW-1:0]           idx_up2;
    logic [CW-1:0]           idx_dn2;
    logic [CW-1:0]           at_p1;

    assign probe_key  = r_rdata[DW-1:HANDLE_WIDTH];
    assign probe_hdl  = r_rdata[HANDLE_WIDTH-1:0];
    assign mid        = r_span >> 1;
    assign at         = r_base + mid;
    assign at_p1      = at + CW'(1);
    assign nb         = (r_key > probe_key) ? at_p1 : r_base;
    assign ns         = (r_key > probe_key) ? (r_span - mid - CW'(1)) : mid;
    assign next_probe = nb + (ns >> 1);
    assign cnt_m1     = r_count - CW'(1);
    assign idx_up     = r_idx + CW'(1);
    assign idx_dn     = r_idx - CW'(1);
    assign idx_up2    = r_idx + CW'(2);
    assign idx_dn2    = r_idx - CW'(2);

    assign o_valid      = r_ovalid;
    assign o_status     = r_o_status;
    assign o_where      = r_o_where;
    assign o_handle_out = r_o_hout;
    assign o_key_out    = r_o_kout;
    assign o_count      = r_o_count;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_handle   = r_handle;
        n_pos      = r_pos;
        n_count    = r_count;
        n_base     = r_base;
        n_span     = r_span;
        n_idx      = r_idx;
        n_status   = r_status;
        n_where    = r_where;
        n_hout     = r_hout;
        n_kout     = r_kout;
        n_ovalid   = r_ovalid && i_stall;
        n_o_status = r_o_status;
        n_o_where  = r_o_where;
        n_o_hout   = r_o_hout;
        n_o_kout   = r_o_kout;
        n_o_count  = r_o_count;
        o_cmd_take = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_idx[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_idx[AW-1:0];
        wr_data    = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_op       = i_cmd_op;
                    n_key      = i_cmd_key;
                    n_handle   = i_cmd_handle;
                    n_pos      = i_cmd_pos;
                    n_status   = ST_OK;
                    n_where    = '0;
                    n_hout     = '0;
                    n_kout     = '0;
                    unique case (i_cmd_op)
                        OP_FIND, OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_MISSING;
                                n_state  = S_DONE;
                            end else begin
                                n_base  = '0;
                                n_span  = r_count;
                                rd_en   = 1'b1;
                                rd_addr = AW'(r_count >> 1);
                                n_state = S_PROBE;
                            end
                        end
                        OP_INSERT: begin
                            priority if (r_count == FULL_COUNT) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (i_cmd_pos > r_count) begin
                                n_status = ST_BEYOND;
                                n_state  = S_DONE;
                            end else if (i_cmd_pos == r_count) begin
                                n_state = S_PLACE;
                            end else begin
                                n_idx   = r_count;
                                rd_en   = 1'b1;
                                rd_addr = cnt_m1[AW-1:0];
                                n_state = S_SHIFT_UP;
                            end
                        end
                        OP_READ: begin
                            if (i_cmd_pos >= r_count) begin
                                n_status = ST_BEYOND;
                                n_state  = S_DONE;
                            end else begin
                                n_where = i_cmd_pos;
                                rd_en   = 1'b1;
                                rd_addr = i_cmd_pos[AW-1:0];
                                n_state = S_READ;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PROBE: begin
                if (r_key == probe_key) begin
                    n_where = at;
                    n_hout  = probe_hdl;
                    if (r_op == OP_REMOVE) begin
                        if (at_p1 == r_count) begin
                            // last entry goes, nothing to close up
                            n_count = cnt_m1;
                            n_state = S_DONE;
                        end else begin
                            n_idx   = at;
                            rd_en   = 1'b1;
                            rd_addr = at_p1[AW-1:0];
                            n_state = S_SHIFT_DN;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (ns == '0) begin
                    n_status = ST_MISSING;
                    n_where  = nb;
                    n_state  = S_DONE;
                end else begin
                    n_base  = nb;
                    n_span  = ns;
                    rd_en   = 1'b1;
                    rd_addr = next_probe[AW-1:0];
                end
            end
            S_SHIFT_DN: begin
                // entry idx+1 moves down to idx, next read runs one ahead
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = r_rdata;
                n_idx   = idx_up;
                if (idx_up == cnt_m1) begin
                    n_count = cnt_m1;
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_up2[AW-1:0];
                end
            end
            S_SHIFT_UP: begin
                // entry idx-1 moves up to idx
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = r_rdata;
                n_idx   = idx_dn;
                if (idx_dn == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_dn2[AW-1:0];
                end
            end
            S_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[AW-1:0];
                wr_data = {r_key, r_handle};
                n_count = r_count + CW'(1);
                n_where = r_pos;
                n_state = S_DONE;
            end
            S_READ: begin
                n_kout  = probe_key;
                n_hout  = probe_hdl;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_where  = r_where;
                    n_o_hout   = r_hout;
                    n_o_kout   = r_kout;
                    n_o_count  = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_handle   <= n_handle;
        r_pos      <= n_pos;
        r_base     <= n_base;
        r_span     <= n_span;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_where    <= n_where;
        r_hout     <= n_hout;
        r_kout     <= n_kout;
        r_o_status <= n_o_status;
        r_o_where  <= n_o_where;
        r_o_hout   <= n_o_hout;
        r_o_kout   <= n_o_kout;
        r_o_count  <= n_o_count;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

/* src/sorted_key_table.sv */
// top level of the sorted key table: front queue plus table engine
//
// sorted key table: holds up to CAPACITY (key, handle) pairs in a table memory
// with one read and one write port; ascending unsigned key order holds only if
// the user inserts each key at its sorted position, the block does not enforce it.
// each input transfer is one operation: find (binary search), insert at a given
// position, remove by key, or read at an index; each yields exactly one output
// transfer carrying the status, the position, the handle and key where they
// apply, and the entry count after the operation. the front decodes and queues
// up to two commands, so input transfers keep flowing while the engine works or
// while a result waits, until the queue is full. in the engine a find makes p
// halving probes (at most log2(count) + 1, none on an empty table), a remove
// makes p probes then closes up s = count - 1 - found position entries, an insert
// moves count - position entries up then writes the new one, a read-at reads one
// entry, and a full or past-count status needs no memory access. the memory needs
// no clearing after reset: only entries below the count are ever read.
module sorted_key_table #(
    parameter int CAPACITY     = 1024,
    parameter int KEY_WIDTH    = 32,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_kind,
    input  logic [KEY_WIDTH-1:0]                i_key,
    input  logic [HANDLE_WIDTH-1:0]             i_handle,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_position,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic [$clog2(CAPACITY+1)-1:0]       o_where,
    output logic [HANDLE_WIDTH-1:0]             o_handle_out,
    output logic [KEY_WIDTH-1:0]                o_key_out,
    output logic [$clog2(CAPACITY+1)-1:0]       o_count
);
    import skt_pkg::*;

    // position, index and count width: holds 0 .. CAPACITY
    localparam int CW = $clog2(CAPACITY + 1);

    // command path from the front queue to the engine
    logic                    cmd_valid;
    logic                    cmd_take;
    t_op                     cmd_op;
    logic [KEY_WIDTH-1:0]    cmd_key;
    logic [HANDLE_WIDTH-1:0] cmd_handle;
    logic [CW-1:0]           cmd_pos;
    t_status                 res_status;

    // front: takes the transfer, decodes the kind, queues the command
    skt_front #(
        .KEY_WIDTH    (KEY_WIDTH),
        .HANDLE_WIDTH (HANDLE_WIDTH),
        .POS_WIDTH    (CW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_handle     (i_handle),
        .i_position   (i_position),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_take   (cmd_take),
        .o_cmd_op     (cmd_op),
        .o_cmd_key    (cmd_key),
        .o_cmd_handle (cmd_handle),
        .o_cmd_pos    (cmd_pos)
    );

    // engine: searches, shifts entries through the memory, registers the result
    skt_engine #(
        .CAPACITY     (CAPACITY),
        .KEY_WIDTH    (KEY_WIDTH),
        .HANDLE_WIDTH (HANDLE_WIDTH),
        .POS_WIDTH    (CW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_take   (cmd_take),
        .i_cmd_op     (cmd_op),
        .i_cmd_key    (cmd_key),
        .i_cmd_handle (cmd_handle),
        .i_cmd_pos    (cmd_pos),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (res_status),
        .o_where      (o_where),
        .o_handle_out (o_handle_out),
        .o_key_out    (o_key_out),
        .o_count      (o_count)
    );

    assign o_status = res_status;

endmodule

/* verif/sorted_key_table_tb.sv */
// testbench for the sorted key table: directed table of operations, then random operation mixes
module sorted_key_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int CAP         = 1024;
    localparam int PW          = $clog2(CAP + 1);
    // worst item: an insert at 0 of 1023 entries moves every entry up the table;
    // LIMIT covers a full run of such items plus stalls and gaps
    localparam int LIMIT       = 8_000_000;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off in phase three
    localparam int SETTLE      = 40;    // quiet cycles after the last result

    // one result transfer, field by field
    typedef struct packed {
        t_status         status;
        logic [PW-1:0]   where;
        logic [31:0]     handle_out;
        logic [31:0]     key_out;
        logic [PW-1:0]   count;
    } t_result;

    // one row of the directed table; rows with fixed set carry a typed-in result
    typedef struct packed {
        logic [1:0]      kind;
        logic [31:0]     key;
        logic [31:0]     handle;
        logic [PW-1:0]   pos;
        logic            fixed;
        t_result         want;
    } t_row;

    localparam t_result NONE = '0;

    // opening sequence: empty table, bad positions, extreme keys and handles,
    // an insert that breaks key order, then searches and removes over that order
    localparam int N_ROWS = 27;
    localparam t_row DIRECTED [0:N_ROWS-1] = '{
        // empty table: every lookup misses, every positioned access is past the count
        '{KIND_FIND,   32'h0,         32'h0,         11'd0,    1'b1,
            '{ST_MISSING, 11'd0, 32'h0,         32'h0,         11'd0}},
        '{KIND_READ,   32'h0,         32'h0,         11'd0,    1'b1,
            '{ST_BEYOND,  11'd0, 32'h0,         32'h0,         11'd0}},
        '{KIND_REMOVE, 32'hFFFF_FFFF, 32'h0,         11'd0,    1'b1,
            '{ST_MISSING, 11'd0, 32'h0,         32'h0,         11'd0}},
        '{KIND_INSERT, 32'h1,         32'h1,         11'd1,    1'b1,
            '{ST_BEYOND,  11'd0, 32'h0,         32'h0,         11'd0}},
        '{KIND_INSERT, 32'h1,         32'h1,         11'd1024, 1'b1,
            '{ST_BEYOND,  11'd0, 32'h0,         32'h0,         11'd0}},
        // smallest and largest keys with opposite extreme handles
        '{KIND_INSERT, 32'h0,         32'hFFFF_FFFF, 11'd0,    1'b1,
            '{ST_OK,      11'd0, 32'h0,         32'h0,         11'd1}},
        '{KIND_INSERT, 32'hFFFF_FFFF, 32'h0,         11'd1,    1'b1,
            '{ST_OK,      11'd1, 32'h0,         32'h0,         11'd2}},
        '{KIND_FIND,   32'hFFFF_FFFF, 32'h0,         11'd0,    1'b1,
            '{ST_OK,      11'd1, 32'h0,         32'h0,         11'd2}},
        '{KIND_FIND,   32'h0,         32'h0,         11'd0,    1'b1,
            '{ST_OK,      11'd0, 32'hFFFF_FFFF, 32'h0,         11'd2}},
        '{KIND_READ,   32'h0,         32'h0,         11'd1,    1'b1,
            '{ST_OK,      11'd1, 32'h0,         32'hFFFF_FFFF, 11'd2}},
        '{KIND_READ,   32'h0,         32'h0,         11'd0,    1'b1,
            '{ST_OK,      11'd0, 32'hFFFF_FFFF, 32'h0,         11'd2}},
        '{KIND_READ,   32'h0,         32'h0,         11'd2,    1'b1,
            '{ST_BEYOND,  11'd0, 32'h0,         32'h0,         11'd2}},
        '{KIND_READ,   32'h0,         32'h0,         11'd1024, 1'b1,
            '{ST_BEYOND,  11'd0, 32'h0,         32'h0,         11'd2}},
        // from here on the predictor supplies the result
        '{KIND_FIND,   32'h8000_0000, 32'h0,         11'd0,    1'b0, NONE},
        '{KIND_INSERT, 32'h8000_0000, 32'h1234_5678, 11'd1,    1'b0, NONE},
        // key 7 after the largest key: table is now out of order
        '{KIND_INSERT, 32'h7,         32'hA5A5_A5A5, 11'd3,    1'b0, NONE},
        '{KIND_FIND,   32'h7,         32'h0,         11'd0,    1'b0, NONE},
        '{KIND_REMOVE, 32'h8000_0000, 32'h0,         11'd0,    1'b0, NONE},
        '{KIND_REMOVE, 32'h8000_0000, 32'h0,         11'd0,    1'b0, NONE},
        // duplicate key at the front
        '{KIND_INSERT, 32'h0,         32'h5A5A_5A5A, 11'd0,    1'b0, NONE},
        '{KIND_FIND,   32'h0,         32'h0,         11'd0,    1'b0, NONE},
        '{KIND_REMOVE, 32'h7,         32'h0,         11'd0,    1'b0, NONE},
        '{KIND_READ,   32'h0,         32'h0,         11'd3,    1'b0, NONE},
        '{KIND_REMOVE, 32'h0,         32'h0,         11'd0,    1'b0, NONE},
        '{KIND_REMOVE, 32'h0,         32'h0,         11'd0,    1'b0, NONE},
        '{KIND_REMOVE, 32'hFFFF_FFFF, 32'h0,         11'd0,    1'b0, NONE},
        '{KIND_FIND,   32'hFFFF_FFFF, 32'h0,         11'd0,    1'b0, NONE}
    };

    // block ports
    logic              i_clk;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              o_stall;
    logic [1:0]        i_kind     = KIND_FIND;
    logic [31:0]       i_key      = '0;
    logic [31:0]       i_handle   = '0;
    logic [PW-1:0]     i_position = '0;
    logic              o_valid;
    logic              i_stall    = 1'b0;
    logic [1:0]        o_status;
    logic [PW-1:0]     o_where;
    logic [31:0]       o_handle_out;
    logic [31:0]       o_key_out;
    logic [PW-1:0]     o_count;

    // shadow copy of the table, updated as each operation is accepted
    logic [31:0]       shadow_key    [0:CAP-1];
    logic [31:0]       shadow_handle [0:CAP-1];
    int                shadow_count = 0;

    t_result           pending_results [$];   // oldest first

    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    bit                hold_req      = 1'b0;
    int                errors        = 0;
    int                peak_count    = 0;
    int                ops_sent    [4] = '{0, 0, 0, 0};
    int                status_seen [4] = '{0, 0, 0, 0};
    int unsigned       cycle_count   = 0;

    sorted_key_table DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // binary search over whatever order the shadow table holds;
    // at gets the hit position or the insertion point
    function automatic bit locate(input logic [31:0] key, output int at);
        int span;
        int base;
        int mid;
        span = shadow_count;
        base = 0;
        while (span > 0) begin
            mid = span / 2;
            if (key == shadow_key[base + mid]) begin
                at = base + mid;
                return 1'b1;
            end
            if (key > shadow_key[base + mid]) begin
                span -= mid + 1;
                base += mid + 1;
            end else begin
                span = mid;
            end
        end
        at = base;
        return 1'b0;
    endfunction

    // apply one operation to the shadow table and return the result it gives
    function automatic t_result table_op_result(input logic [1:0] kind, input logic [31:0] key,
                                                input logic [31:0] handle,
                                                input logic [PW-1:0] pos);
        t_result r;
        int      at;
        int      i;
        r  = '0;
        at = 0;
        case (kind)
            KIND_FIND: begin
                if (locate(key, at)) r.handle_out = shadow_handle[at];
                else r.status = ST_MISSING;
                r.where = PW'(at);
            end
            KIND_INSERT: begin
                // full is checked before the position
                if (shadow_count >= CAP) begin
                    r.status = ST_FULL;
                end else if (pos > shadow_count) begin
                    r.status = ST_BEYOND;
                end else begin
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_key[i]    = shadow_key[i - 1];
                        shadow_handle[i] = shadow_handle[i - 1];
                    end
                    shadow_key[pos]    = key;
                    shadow_handle[pos] = handle;
                    shadow_count++;
                    r.where = pos;
                end
            end
            KIND_REMOVE: begin
                if (locate(key, at)) begin
                    r.handle_out = shadow_handle[at];
                    shadow_count--;
                    for (i = at; i < shadow_count; i++) begin
                        shadow_key[i]    = shadow_key[i + 1];
                        shadow_handle[i] = shadow_handle[i + 1];
                    end
                end else begin
                    r.status = ST_MISSING;
                end
                r.where = PW'(at);
            end
            default: begin
                if (pos >= shadow_count) begin
                    r.status = ST_BEYOND;
                end else begin
                    r.key_out    = shadow_key[pos];
                    r.handle_out = shadow_handle[pos];
                    r.where      = pos;
                end
            end
        endcase
        r.count = PW'(shadow_count);
        return r;
    endfunction

    // offer one operation, wait for its transfer, then record what it should give
    task automatic offer(input logic [1:0] kind, input logic [31:0] key,
                         input logic [31:0] handle, input logic [PW-1:0] pos,
                         input bit fixed, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        i_handle   <= handle;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
        // the shadow table always advances, even on rows with a typed-in result
        predicted = table_op_result(kind, key, handle, pos);
        pending_results.push_back(fixed ? want : predicted);
        ops_sent[kind]++;
    endtask

    // mostly keys already held or their neighbors, so hits and removes are common
    function automatic logic [31:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (shadow_count > 0 && roll < 45) return shadow_key[$urandom_range(shadow_count - 1)];
        if (shadow_count > 0 && roll < 55)
            return shadow_key[$urandom_range(shadow_count - 1)] + 32'd1;
        if (roll < 65) return 32'($urandom_range(255));
        if (roll < 70) return roll[0] ? 32'hFFFF_FFFF : 32'h0;
        return $urandom();
    endfunction

    // random operation that drifts the entry count toward target;
    // inserts go mostly to the sorted position, a few anywhere or past the count
    task automatic offer_random(input int target);
        int unsigned    roll;
        logic [1:0]     kind;
        logic [31:0]    key;
        logic [PW-1:0]  pos;
        int             at;
        roll = $urandom_range(99);
        if (shadow_count < target)
            kind = roll < 40 ? KIND_INSERT : roll < 65 ? KIND_FIND :
                   roll < 80 ? KIND_REMOVE : KIND_READ;
        else
            kind = roll < 15 ? KIND_INSERT : roll < 40 ? KIND_FIND :
                   roll < 80 ? KIND_REMOVE : KIND_READ;
        key  = pick_key();
        roll = $urandom_range(99);
        case (kind)
            KIND_INSERT: begin
                if (roll < 85) begin
                    void'(locate(key, at));
                    pos = PW'(at);
                end else if (roll < 93 || shadow_count >= CAP) begin
                    pos = PW'($urandom_range(shadow_count));
                end else begin
                    pos = PW'($urandom_range(CAP, shadow_count + 1));
                end
            end
            KIND_READ: begin
                if (roll < 85 && shadow_count > 0) pos = PW'($urandom_range(shadow_count - 1));
                else pos = PW'($urandom_range(CAP, shadow_count));
            end
            default: pos = PW'($urandom_range(CAP));   // unused field, random noise
        endcase
        offer(kind, key, $urandom(), pos, 1'b0, NONE);
    endtask

    // sender pause: nothing offered until every expected result has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, or one long hold-off when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    // result side: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{t_status'(o_status), o_where, o_handle_out, o_key_out, o_count};
            status_seen[o_status]++;
            if (int'(o_count) > peak_count) peak_count = int'(o_count);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got status %0d where %0d count %0d",
                         $time, o_status, o_where, o_count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",     32'(want.status), 32'(got.status));
                check_field("where",      32'(want.where),  32'(got.where));
                check_field("handle_out", want.handle_out,  got.handle_out);
                check_field("key_out",    want.key_out,     got.key_out);
                check_field("count",      32'(want.count),  32'(got.count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("** sorted_key_table: FAILED **");
            $finish;
        end
    end

    initial begin
        int          n;
        int          at;
        logic [31:0] key;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase one: sender mostly busy, receiver mostly stalled
        send_idle_pct = 19;
        recv_idle_pct = 65;
        for (n = 0; n < N_ROWS; n++)
            offer(DIRECTED[n].kind, DIRECTED[n].key, DIRECTED[n].handle, DIRECTED[n].pos,
                  DIRECTED[n].fixed, DIRECTED[n].want);
        for (n = 0; n < 500; n++) offer_random(48);
        drain();

        // phase two: roles swapped, table allowed to grow larger
        send_idle_pct = 65;
        recv_idle_pct = 19;
        for (n = 0; n < 500; n++) offer_random(200);
        drain();

        // phase three: no idling; long receiver hold-off backs up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        for (n = 0; n < 40; n++) offer_random(200);

        // fill to capacity with random keys at their sorted positions
        while (shadow_count < CAP) begin
            key = $urandom();
            void'(locate(key, at));
            offer(KIND_INSERT, key, $urandom(), PW'(at), 1'b0, NONE);
        end
        // full table: full wins even over an insert at the count
        offer(KIND_INSERT, 32'h1, 32'h1, 11'd1024, 1'b1,
              '{ST_FULL, 11'd0, 32'h0, 32'h0, 11'd1024});
        offer(KIND_INSERT, 32'h0, 32'h0, 11'd0, 1'b1,
              '{ST_FULL, 11'd0, 32'h0, 32'h0, 11'd1024});
        offer(KIND_READ, 32'h0, 32'h0, 11'd1024, 1'b1,
              '{ST_BEYOND, 11'd0, 32'h0, 32'h0, 11'd1024});
        for (n = 0; n < 60; n++) offer_random(CAP);
        drain();

        repeat (SETTLE) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            errors++;
        end

        $display("covered find %0d, insert %0d, remove %0d, read-at %0d; peak %0d entries",
                 ops_sent[KIND_FIND], ops_sent[KIND_INSERT], ops_sent[KIND_REMOVE],
                 ops_sent[KIND_READ], peak_count);
        $display("statuses: ok %0d, missing %0d, full %0d, past count %0d; %0d mismatches",
                 status_seen[ST_OK], status_seen[ST_MISSING], status_seen[ST_FULL],
                 status_seen[ST_BEYOND], errors);
        if (errors == 0) begin
            $display("** sorted_key_table: PASSED **");
        end else begin
            $display("** sorted_key_table: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
src/skt_pkg.sv
src/skt_front.sv
src/skt_engine.sv
src/sorted_key_table.sv
verif/sorted_key_table_tb.sv
